// ----- design/ppwt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppwt_pkg
// shared types and constants of the priority scheduler wait-time block
// ----------------------------------------------------------------------------
package ppwt_pkg;

    localparam int MAX_JOBS   = 16;
    localparam int IDX_W      = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W      = $clog2(MAX_JOBS + 1);
    localparam int BURST_W    = 16;
    localparam int URG_W      = 8;
    localparam int TIME_W     = 20;
    localparam int NO_URGENCY = 9999;
    localparam int BEST_W     = $clog2(NO_URGENCY + 1);

    typedef struct packed {
        logic [BURST_W-1:0] burst_length;
        logic [URG_W-1:0]   priority_level;
        logic               is_last;
    } t_job_in;

    typedef struct packed {
        logic [3:0]        job_index;
        logic [TIME_W-1:0] wait_time;
        logic [TIME_W-1:0] turnaround_time;
        logic              last_result;
    } t_job_out;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic sched_init;
        logic scan_step;
        logic commit;
        logic emit_init;
        logic emit_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic idx_last;
        logic found;
        logic out_free;
    } t_sts;

endpackage

// ----- design/ppwt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppwt_ctrl
// sequencer: load, scan for the most urgent job, commit it, emit results
// ----------------------------------------------------------------------------
module ppwt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_is_last,
    input  ppwt_pkg::t_sts i_sts,
    output ppwt_pkg::t_cmd o_cmd,
    output logic           o_stall
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_is_last) begin
                        o_cmd.sched_init = 1'b1;
                        n_state          = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (i_sts.found) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_SCAN;
                end else begin
                    o_cmd.emit_init = 1'b1;
                    n_state         = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_load = 1'b1;
                    if (i_sts.idx_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- design/ppwt_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppwt_dpath
// job stores, urgency scan, clock and wait update, result register
// ----------------------------------------------------------------------------
module ppwt_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ppwt_pkg::t_cmd     i_cmd,
    input  ppwt_pkg::t_job_in  i_data,
    input  logic               i_stall,
    output ppwt_pkg::t_sts     o_sts,
    output logic               o_valid,
    output ppwt_pkg::t_job_out o_data
);

    localparam int IDX_W   = ppwt_pkg::IDX_W;
    localparam int CNT_W   = ppwt_pkg::CNT_W;
    localparam int BURST_W = ppwt_pkg::BURST_W;
    localparam int URG_W   = ppwt_pkg::URG_W;
    localparam int TIME_W  = ppwt_pkg::TIME_W;
    localparam int BEST_W  = ppwt_pkg::BEST_W;
    localparam logic [BEST_W-1:0] NO_URG = BEST_W'(ppwt_pkg::NO_URGENCY);

    logic [BURST_W-1:0]        r_burst [ppwt_pkg::MAX_JOBS];
    logic [URG_W-1:0]          r_urg   [ppwt_pkg::MAX_JOBS];
    logic [TIME_W-1:0]         r_wait  [ppwt_pkg::MAX_JOBS];
    logic [ppwt_pkg::MAX_JOBS-1:0] r_done;

    logic [CNT_W-1:0]   r_count;
    logic [IDX_W-1:0]   r_idx;
    logic [TIME_W-1:0]  r_tick;
    logic [BEST_W-1:0]  r_best;
    logic [IDX_W-1:0]   r_best_idx;
    logic [BURST_W-1:0] r_best_burst;
    logic               r_out_valid;
    ppwt_pkg::t_job_out r_out;

    logic [BURST_W-1:0] cur_burst;
    logic               eligible;
    logic [TIME_W:0]    fin_sum;
    logic [TIME_W-1:0]  fin;
    logic [TIME_W-1:0]  wait_sel;

    assign cur_burst = r_burst[r_idx];
    assign eligible  = !r_done[r_idx] && (cur_burst != '0)
                       && ({{(BEST_W-URG_W){1'b0}}, r_urg[r_idx]} < r_best);

    // run the chosen job to completion, clock saturates
    assign fin_sum = {1'b0, r_tick} + (TIME_W+1)'(r_best_burst);
    assign fin     = fin_sum[TIME_W] ? '1 : fin_sum[TIME_W-1:0];

    // zero-length jobs never get a wait written
    assign wait_sel = (cur_burst == '0) ? '0 : r_wait[r_idx];

    assign o_sts.idx_last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    assign o_sts.found    = (r_best != NO_URG);
    assign o_sts.out_free = !r_out_valid || !i_stall;

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_count < CNT_W'(ppwt_pkg::MAX_JOBS))) begin
            r_burst[r_count[IDX_W-1:0]] <= i_data.burst_length;
            r_urg[r_count[IDX_W-1:0]]   <= i_data.priority_level;
        end
        if (i_cmd.commit) begin
            r_wait[r_best_idx] <= fin - TIME_W'(r_best_burst);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step && eligible) begin
            r_best_idx   <= r_idx;
            r_best_burst <= cur_burst;
        end
        if (i_cmd.emit_load) begin
            r_out.job_index       <= 4'(r_idx);
            r_out.wait_time       <= wait_sel;
            r_out.turnaround_time <= wait_sel + TIME_W'(cur_burst);
            r_out.last_result     <= o_sts.idx_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_tick      <= '0;
            r_best      <= NO_URG;
            r_done      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load && (r_count < CNT_W'(ppwt_pkg::MAX_JOBS))) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.sched_init) begin
                r_tick <= '0;
                r_done <= '0;
                r_idx  <= '0;
                r_best <= NO_URG;
            end
            if (i_cmd.scan_step) begin
                r_idx <= r_idx + IDX_W'(1);
                if (eligible) begin
                    r_best <= BEST_W'(r_urg[r_idx]);
                end
            end
            if (i_cmd.commit) begin
                r_tick             <= fin;
                r_done[r_best_idx] <= 1'b1;
                r_idx              <= '0;
                r_best             <= NO_URG;
            end
            if (i_cmd.emit_init) begin
                r_idx <= '0;
            end
            if (i_cmd.emit_load) begin
                r_idx <= r_idx + IDX_W'(1);
                if (o_sts.idx_last) begin
                    r_count <= '0;
                end
            end
            if (i_cmd.emit_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- design/preemptive_priority_wait_times.sv -----
`timescale 1ns / 1ps
// load beat: one job per beat while idle; a set closes on the beat with is_last
// schedule: (k+1) scans over the job stores, n jobs stored, k with nonzero burst,
// one scan per completed job and a final one, then n result beats, one per cycle unless stalled
// no new beat is taken from the scan until the last result is loaded out
// reset (synchronous, active low) empties the set and invalidates the result register
// ----------------------------------------------------------------------------
// preemptive_priority_wait_times
// priority scheduler returning waiting and turnaround time per job
// ----------------------------------------------------------------------------
module preemptive_priority_wait_times (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  ppwt_pkg::t_job_in  i_data,
    output logic               o_stall,
    output logic               o_valid,
    output ppwt_pkg::t_job_out o_data,
    input  logic               i_stall
);

    ppwt_pkg::t_cmd cmd;
    ppwt_pkg::t_sts sts;

    ppwt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_is_last (i_data.is_last),
        .i_sts     (sts),
        .o_cmd     (cmd),
        .o_stall   (o_stall)
    );

    ppwt_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_data  (i_data),
        .i_stall (i_stall),
        .o_sts   (sts),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

endmodule

// ----- design/ppwt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppwt_checker
// port-level checks of the scheduler, bound to the top level
// ----------------------------------------------------------------------------
module ppwt_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input ppwt_pkg::t_job_in  i_data,
    input logic               o_stall,
    input logic               o_valid,
    input ppwt_pkg::t_job_out o_data,
    input logic               i_stall
);

    // a closing beat starts the schedule, so input stalls next cycle
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_data.is_last) |=> o_stall)
        else $error("no stall after closing beat");

    a_turn_ge_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.turnaround_time >= o_data.wait_time))
        else $error("turnaround below wait");

    // results of a set come back to back in index order
    a_index_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_data.last_result) |=>
            (o_valid && (o_data.job_index == 4'($past(o_data.job_index) + 4'd1))))
        else $error("result index out of order");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("stalled result changed");

endmodule

bind preemptive_priority_wait_times ppwt_checker u_ppwt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .i_data  (i_data),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .o_data  (o_data),
    .i_stall (i_stall)
);
